>>> rtl/core/aim_cone_marker_pick_macros.svh
// Assertion macros used by the checker of the aim cone marker picker.
// Depends on nothing; included by the checker file.
`ifndef AIM_CONE_MARKER_PICK_MACROS_SVH
`define AIM_CONE_MARKER_PICK_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define ACMP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("acmp assertion failed");

// Consequent holds in the cycle after the antecedent.
`define ACMP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("acmp assertion failed");

`endif

>>> rtl/core/acmp_pkg.sv
// Package of the aim cone marker picker: constants, codes and the
// controller to datapath command and status types. Depends on nothing.
package acmp_pkg;

   localparam int MAX_MARKERS_DEF = 32;
   localparam int COORD_BITS_DEF  = 24;

   localparam logic [15:0] SIN_A   = 16'd51472;
   localparam logic [15:0] SIN_B   = 16'd21024;
   localparam logic [15:0] SIN_C   = 16'd2320;
   localparam logic [15:0] QUARTER = 16'd16384;
   localparam logic [16:0] ONE_Q15 = 17'd32768;

   localparam logic [15:0] THRESH_RESET = 16'd32440;
   localparam logic [5:0]  COUNT_RESET  = 6'd0;

   localparam logic [1:0] CSR_MARKER_COUNT  = 2'd0;
   localparam logic [1:0] CSR_AIM_THRESHOLD = 2'd1;

   localparam logic OPC_WRITE = 1'b0;
   localparam logic OPC_QUERY = 1'b1;

   localparam int FWD_OPS     = 18;
   localparam int MARKER_OPS  = 6;
   localparam int DIV_STEPS   = 17;
   localparam int CLOSE_LIMIT = 65536;

   typedef enum logic [3:0] {
      MUL_ZZ, MUL_CZ2, MUL_TZ2, MUL_TZ, MUL_FX, MUL_FY,
      MUL_DXX, MUL_DYY, MUL_DZZ, MUL_DXF, MUL_DYF, MUL_DZF
   } mul_op_type;

   typedef struct packed {
      logic       start;
      logic       wr_en;
      logic       rd_en;
      logic       load;
      logic       mul_go;
      logic       wb;
      mul_op_type mul_op;
      logic [1:0] sine_sel;
      logic       sq_step;
      logic       div_init;
      logic       div_step;
      logic       cmp;
      logic       close;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic close;
   } status_type;

endpackage

>>> rtl/core/acmp_ram.sv
// Generic single write port RAM with one registered read port.
// Depends on nothing.
module acmp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/acmp_ctrl.sv
// Controller of the aim cone marker picker: handshakes, marker count
// register and the sequence of datapath commands. Depends on acmp_pkg.
module acmp_ctrl import acmp_pkg::*; #(
   parameter int MAX_MARKERS = MAX_MARKERS_DEF,
   parameter int COORD_BITS  = COORD_BITS_DEF,
   localparam int IW = $clog2(MAX_MARKERS),
   localparam int CW = IW + 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_opcode,
   input  logic [4:0]    req_slot,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_wdata,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  status_type    status,
   output cmd_type       cmd,
   output logic [IW-1:0] mark_index
);

   localparam int SQ         = COORD_BITS + 2;
   localparam int FWD_CYCLES = 2 * FWD_OPS;
   localparam int MUL_CYCLES = 2 * MARKER_OPS;
   localparam int STEP_W     = $clog2((FWD_CYCLES > SQ) ? FWD_CYCLES : SQ);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_FWD    = 10'b0000000010,
      S_RD     = 10'b0000000100,
      S_LOAD   = 10'b0000001000,
      S_MUL    = 10'b0000010000,
      S_SQRT   = 10'b0000100000,
      S_DIVI   = 10'b0001000000,
      S_DIV    = 10'b0010000000,
      S_CMP    = 10'b0100000000,
      S_FINISH = 10'b1000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [5:0]        count_ff, count_in;
   logic              close_ff, close_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]     n_eff;
   logic [STEP_W-2:0] k;
   logic              accept;

   assign n_eff = (9'(count_ff) > 9'(MAX_MARKERS)) ? CW'(MAX_MARKERS) : CW'(count_ff);
   assign k = step_ff[STEP_W-1:1];
   assign req_ready = (state_ff == S_IDLE);
   assign accept = req_valid && req_ready;
   assign mark_index = idx_ff[IW-1:0];
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      count_in = count_ff;
      if (csr_we && (csr_index == CSR_MARKER_COUNT)) begin
         count_in = csr_wdata[5:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      idx_in   = idx_ff;
      close_in = close_ff;
      cmd      = '0;
      cmd.mul_op = MUL_ZZ;
      cmd.close  = close_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_opcode == OPC_WRITE) begin
                  cmd.wr_en = (9'(req_slot) < 9'(MAX_MARKERS));
               end else begin
                  cmd.start = 1'b1;
                  step_in   = '0;
                  state_in  = S_FWD;
               end
            end
         end
         S_FWD: begin
            cmd.mul_go = ~step_ff[0];
            cmd.wb     = step_ff[0];
            if (k < 16) begin
               cmd.sine_sel = k[3:2];
               unique case (k[1:0])
                  2'd0: cmd.mul_op = MUL_ZZ;
                  2'd1: cmd.mul_op = MUL_CZ2;
                  2'd2: cmd.mul_op = MUL_TZ2;
                  2'd3: cmd.mul_op = MUL_TZ;
               endcase
            end else if (k == 16) begin
               cmd.mul_op = MUL_FX;
            end else begin
               cmd.mul_op = MUL_FY;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(FWD_CYCLES - 1)) begin
               idx_in   = '0;
               state_in = (n_eff == '0) ? S_FINISH : S_RD;
            end
         end
         S_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_LOAD;
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            step_in  = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul_go = ~step_ff[0];
            cmd.wb     = step_ff[0];
            unique case (k[2:0])
               3'd0:    cmd.mul_op = MUL_DXX;
               3'd1:    cmd.mul_op = MUL_DYY;
               3'd2:    cmd.mul_op = MUL_DZZ;
               3'd3:    cmd.mul_op = MUL_DXF;
               3'd4:    cmd.mul_op = MUL_DYF;
               default: cmd.mul_op = MUL_DZF;
            endcase
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(MUL_CYCLES - 1)) begin
               close_in = status.close;
               step_in  = '0;
               state_in = status.close ? S_CMP : S_SQRT;
            end
         end
         S_SQRT: begin
            cmd.sq_step = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(SQ - 1)) begin
               state_in = S_DIVI;
            end
         end
         S_DIVI: begin
            cmd.div_init = 1'b1;
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            cmd.cmp = 1'b1;
            idx_in  = idx_ff + 1'b1;
            state_in = ((CW+1)'(idx_ff) + 1'b1 < (CW+1)'(n_eff)) ? S_RD : S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         idx_ff       <= '0;
         close_ff     <= 1'b0;
         count_ff     <= COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         idx_ff       <= idx_in;
         close_ff     <= close_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/core/acmp_dpath.sv
// Datapath of the aim cone marker picker: marker table, shared multiplier,
// sine, square root and divide steps, best marker tracking and result word.
// Depends on acmp_pkg and acmp_ram.
module acmp_dpath import acmp_pkg::*; #(
   parameter int MAX_MARKERS = MAX_MARKERS_DEF,
   parameter int COORD_BITS  = COORD_BITS_DEF,
   localparam int IW = $clog2(MAX_MARKERS),
   localparam int CB = COORD_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [4:0]           req_slot,
   input  logic signed [CB-1:0] req_pos_x,
   input  logic signed [CB-1:0] req_pos_y,
   input  logic signed [CB-1:0] req_pos_z,
   input  logic [15:0]          req_pitch_angle,
   input  logic [15:0]          req_yaw_angle,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_wdata,
   input  cmd_type              cmd,
   input  logic [IW-1:0]        mark_index,
   output status_type           status,
   output logic                 rsp_hit,
   output logic [4:0]           rsp_marker_index,
   output logic [15:0]          rsp_best_score
);

   localparam int MW  = (CB + 1 > 18) ? CB + 1 : 18;
   localparam int PW  = 2 * MW;
   localparam int SQ  = CB + 2;
   localparam int SQW = 2 * SQ;
   localparam int DW  = CB + 20;

   logic signed [CB-1:0] cam_x_ff, cam_y_ff, cam_z_ff;
   logic [15:0]          pitch_ff, yaw_ff, thresh_ff, thresh_in;
   logic [3*CB-1:0]      rdata;
   logic signed [CB-1:0] mk_x, mk_y, mk_z;
   logic signed [CB:0]   dx_ff, dy_ff, dz_ff;

   logic [15:0]          ang;
   logic [14:0]          sz;
   logic                 sneg;
   logic [14:0]          z2_ff;
   logic [15:0]          t_ff;
   logic signed [16:0]   sp_ff, cp_ff, sy_ff, cy_ff, fx_ff, fy_ff, fz;
   logic signed [16:0]   sval, fq;
   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] prod_ff, rnd;

   logic [SQW-1:0]       sumsq_ff;
   logic signed [DW-1:0] dot_ff;
   logic [SQ-1:0]        root_ff;
   logic [SQ+1:0]        rem_ff, rem_t, trial;
   logic [DW-1:0]        dmag, dhi;
   logic [SQ:0]          drem_ff, drt;
   logic [16:0]          dq_ff, qmag;
   logic                 clamp_ff, neg_ff, ge;
   logic signed [17:0]   score, best_ff;
   logic                 found_ff;
   logic [IW-1:0]        bidx_ff;
   logic                 hit_ff;
   logic [4:0]           oidx_ff;
   logic [15:0]          oscore_ff;

   acmp_ram #(.WIDTH(3 * CB), .DEPTH(MAX_MARKERS)) u_table (
      .clock(clock),
      .we(cmd.wr_en),
      .waddr(IW'(req_slot)),
      .wdata({req_pos_x, req_pos_y, req_pos_z}),
      .re(cmd.rd_en),
      .raddr(mark_index),
      .rdata(rdata)
   );

   assign mk_x = rdata[3*CB-1 -: CB];
   assign mk_y = rdata[2*CB-1 -: CB];
   assign mk_z = rdata[CB-1:0];

   always_comb begin
      unique case (cmd.sine_sel)
         2'd0: ang = pitch_ff;
         2'd1: ang = pitch_ff + QUARTER;
         2'd2: ang = yaw_ff;
         2'd3: ang = yaw_ff + QUARTER;
      endcase
   end

   assign sz   = ang[14] ? 15'(15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
   assign sneg = ang[15];
   assign fz   = -sp_ff;

   always_comb begin
      unique case (cmd.mul_op)
         MUL_ZZ:  begin mul_a = MW'(sz);    mul_b = MW'(sz);    end
         MUL_CZ2: begin mul_a = MW'(SIN_C); mul_b = MW'(z2_ff); end
         MUL_TZ2: begin mul_a = MW'(t_ff);  mul_b = MW'(z2_ff); end
         MUL_TZ:  begin mul_a = MW'(t_ff);  mul_b = MW'(sz);    end
         MUL_FX:  begin mul_a = MW'(cp_ff); mul_b = MW'(cy_ff); end
         MUL_FY:  begin mul_a = MW'(cp_ff); mul_b = MW'(sy_ff); end
         MUL_DXX: begin mul_a = MW'(dx_ff); mul_b = MW'(dx_ff); end
         MUL_DYY: begin mul_a = MW'(dy_ff); mul_b = MW'(dy_ff); end
         MUL_DZZ: begin mul_a = MW'(dz_ff); mul_b = MW'(dz_ff); end
         MUL_DXF: begin mul_a = MW'(dx_ff); mul_b = MW'(fx_ff); end
         MUL_DYF: begin mul_a = MW'(dy_ff); mul_b = MW'(fy_ff); end
         MUL_DZF: begin mul_a = MW'(dz_ff); mul_b = MW'(fz);    end
         default: begin mul_a = '0;         mul_b = '0;         end
      endcase
   end

   assign sval = sneg ? -17'(prod_ff >>> 14) : 17'(prod_ff >>> 14);
   assign rnd  = prod_ff[PW-1] ? PW'(32767) : '0;
   assign fq   = 17'((prod_ff + rnd) >>> 15);

   assign rem_t = {rem_ff[SQ-1:0], sumsq_ff[SQW-1 -: 2]};
   assign trial = {root_ff, 2'b01};

   assign dmag = dot_ff[DW-1] ? DW'(-dot_ff) : DW'(dot_ff);
   assign dhi  = dmag >> DIV_STEPS;
   assign drt  = {drem_ff[SQ-1:0], dq_ff[16]};
   assign ge   = (drt >= {1'b0, root_ff});
   assign qmag = (clamp_ff || (dq_ff > ONE_Q15)) ? ONE_Q15 : dq_ff;
   assign score = neg_ff ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

   assign status.close = (sumsq_ff < SQW'(CLOSE_LIMIT));

   always_comb begin
      thresh_in = thresh_ff;
      if (csr_we && (csr_index == CSR_AIM_THRESHOLD)) begin
         thresh_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cam_x_ff <= req_pos_x;
         cam_y_ff <= req_pos_y;
         cam_z_ff <= req_pos_z;
         pitch_ff <= req_pitch_angle;
         yaw_ff   <= req_yaw_angle;
         found_ff <= 1'b0;
         best_ff  <= $signed({2'b00, thresh_ff});
         bidx_ff  <= '0;
      end
      if (cmd.load) begin
         dx_ff    <= {mk_x[CB-1], mk_x} - {cam_x_ff[CB-1], cam_x_ff};
         dy_ff    <= {mk_y[CB-1], mk_y} - {cam_y_ff[CB-1], cam_y_ff};
         dz_ff    <= {mk_z[CB-1], mk_z} - {cam_z_ff[CB-1], cam_z_ff};
         sumsq_ff <= '0;
         dot_ff   <= '0;
         root_ff  <= '0;
         rem_ff   <= '0;
      end
      if (cmd.mul_go) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.wb) begin
         unique case (cmd.mul_op)
            MUL_ZZ:  z2_ff <= 15'(prod_ff >>> 14);
            MUL_CZ2: t_ff  <= SIN_B - 16'(prod_ff >>> 14);
            MUL_TZ2: t_ff  <= SIN_A - 16'(prod_ff >>> 14);
            MUL_TZ: begin
               unique case (cmd.sine_sel)
                  2'd0: sp_ff <= sval;
                  2'd1: cp_ff <= sval;
                  2'd2: sy_ff <= sval;
                  2'd3: cy_ff <= sval;
               endcase
            end
            MUL_FX:  fx_ff <= fq;
            MUL_FY:  fy_ff <= fq;
            MUL_DXX, MUL_DYY, MUL_DZZ: sumsq_ff <= sumsq_ff + SQW'(unsigned'(prod_ff));
            MUL_DXF, MUL_DYF, MUL_DZF: dot_ff <= dot_ff + DW'(prod_ff);
            default: ;
         endcase
      end
      if (cmd.sq_step) begin
         sumsq_ff <= sumsq_ff << 2;
         if (rem_t >= trial) begin
            rem_ff  <= rem_t - trial;
            root_ff <= {root_ff[SQ-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_t;
            root_ff <= {root_ff[SQ-2:0], 1'b0};
         end
      end
      if (cmd.div_init) begin
         clamp_ff <= (dhi >= DW'(root_ff));
         neg_ff   <= dot_ff[DW-1];
         drem_ff  <= (SQ+1)'(dhi);
         dq_ff    <= dmag[16:0];
      end
      if (cmd.div_step) begin
         drem_ff <= ge ? (drt - {1'b0, root_ff}) : drt;
         dq_ff   <= {dq_ff[15:0], ge};
      end
      if (cmd.cmp) begin
         if (cmd.close) begin
            found_ff <= 1'b1;
            bidx_ff  <= mark_index;
            best_ff  <= $signed({1'b0, ONE_Q15});
         end else if (score > best_ff) begin
            found_ff <= 1'b1;
            bidx_ff  <= mark_index;
            best_ff  <= score;
         end
      end
      if (cmd.out_load) begin
         hit_ff    <= found_ff;
         oidx_ff   <= found_ff ? 5'(bidx_ff) : 5'd0;
         oscore_ff <= found_ff ? best_ff[15:0] : 16'd0;
      end
   end

   assign rsp_hit          = hit_ff;
   assign rsp_marker_index = oidx_ff;
   assign rsp_best_score   = oscore_ff;

endmodule

>>> rtl/core/aim_cone_marker_pick.sv
// Aim cone marker picker, top level: joins the controller and the datapath.
// Depends on acmp_pkg, acmp_ctrl and acmp_dpath.
// A write word gives no result. A query first builds the forward vector on the shared
// multiplier, then per marker reads the table and forms offset, squared distance and dot product;
// a marker that is not close then runs one-bit square root and divide loops; one query at a time.
// Reset is synchronous and clears control and both registers, not the table.
module aim_cone_marker_pick import acmp_pkg::*; #(
   parameter int MAX_MARKERS = MAX_MARKERS_DEF,
   parameter int COORD_BITS  = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_opcode,
   input  logic [4:0]                   req_slot,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   input  logic signed [COORD_BITS-1:0] req_pos_z,
   input  logic [15:0]                  req_pitch_angle,
   input  logic [15:0]                  req_yaw_angle,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_hit,
   output logic [4:0]                   rsp_marker_index,
   output logic [15:0]                  rsp_best_score,
   input  logic                         csr_we,
   input  logic [1:0]                   csr_index,
   input  logic [15:0]                  csr_wdata
);

   localparam int IW = $clog2(MAX_MARKERS);

   cmd_type       cmd;
   status_type    status;
   logic [IW-1:0] mark_index;

   acmp_ctrl #(.MAX_MARKERS(MAX_MARKERS), .COORD_BITS(COORD_BITS)) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_slot(req_slot),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status(status),
      .cmd(cmd),
      .mark_index(mark_index)
   );

   acmp_dpath #(.MAX_MARKERS(MAX_MARKERS), .COORD_BITS(COORD_BITS)) u_dpath (
      .clock(clock),
      .reset(reset),
      .req_slot(req_slot),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_pos_z(req_pos_z),
      .req_pitch_angle(req_pitch_angle),
      .req_yaw_angle(req_yaw_angle),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cmd(cmd),
      .mark_index(mark_index),
      .status(status),
      .rsp_hit(rsp_hit),
      .rsp_marker_index(rsp_marker_index),
      .rsp_best_score(rsp_best_score)
   );

endmodule

>>> rtl/core/acmp_checker.sv
// Port level checker of the aim cone marker picker and its bind.
// Depends on aim_cone_marker_pick_macros.svh and aim_cone_marker_pick.
`include "aim_cone_marker_pick_macros.svh"

module acmp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_opcode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_hit,
   input logic [4:0]  rsp_marker_index,
   input logic [15:0] rsp_best_score
);

   // A miss word carries zero index and zero score.
   `ACMP_ASSERT_SAME(a_miss_zero, clock, reset, rsp_valid && !rsp_hit, (rsp_marker_index == 5'd0) && (rsp_best_score == 16'd0))
   // A score never exceeds one, and a hit never scores zero.
   `ACMP_ASSERT_SAME(a_score_range, clock, reset, rsp_valid && rsp_hit, (rsp_best_score <= 16'd32768) && (rsp_best_score != 16'd0))
   // A query first passes through the forward and marker states, so no word appears right after one is taken.
   `ACMP_ASSERT_NEXT(a_no_instant, clock, reset, req_valid && req_ready && req_opcode, !$rose(rsp_valid))
   // A stalled result word holds.
   `ACMP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hit) && $stable(rsp_marker_index) && $stable(rsp_best_score))

endmodule

bind aim_cone_marker_pick acmp_checker u_acmp_checker (.*);
